### hw/rtl/b64d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  // Character codes with a fixed meaning
  localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;  // '0'
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;  // '9'

  // Alphabet offsets of the letter and digit groups
  localparam logic [5:0] VAL_LOWER_BASE = 6'd26;
  localparam logic [5:0] VAL_DIGIT_BASE = 6'd52;
  localparam logic [5:0] VAL_SYM62      = 6'd62;
  localparam logic [5:0] VAL_SYM63      = 6'd63;

  // Reset values of the alphabet registers: '+' and '/'
  localparam logic [7:0] SYM62_RESET = 8'h2B;
  localparam logic [7:0] SYM63_RESET = 8'h2F;

  // Register index, taken from paddr[2]
  localparam logic REG_SYM62 = 1'b0;
  localparam logic REG_SYM63 = 1'b1;

  // Message status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_TRAILING = 2'd2;

  typedef struct packed {
    logic [5:0] bits;
    logic [2:0] count;
    logic       pad_seen;
    logic [1:0] err;
  } msg_state_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] decoded_byte;
    logic       message_end;
    logic [1:0] status;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/b64d_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] decoded_byte;
  logic       message_end;
  logic [1:0] status;

  modport source (output valid, output byte_valid, output decoded_byte,
                  output message_end, output status, input ready);
  modport sink   (input valid, input byte_valid, input decoded_byte,
                  input message_end, input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/b64d_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One decode step: symbol lookup, bit accumulation, end-of-message check.
module b64d_step
  import b64d_pkg::*;
(
  input  wire logic [7:0] char_code,
  input  wire logic       last_char,
  input  wire logic [7:0] sym62,
  input  wire logic [7:0] sym63,
  input  wire msg_state_t state_cur,
  output msg_state_t      state_nxt,
  output result_t         result
);

  logic [5:0]  sym_val;
  logic        sym_known;
  logic [11:0] acc;
  logic [3:0]  cnt_sum;
  logic [2:0]  cnt_left;
  logic [11:0] acc_shifted;
  logic [6:0]  keep_mask;
  logic        emit;
  msg_state_t  upd;
  logic [7:0]  diff_upper;
  logic [7:0]  diff_lower;
  logic [7:0]  diff_digit;

  assign diff_upper = char_code - CHAR_UPPER_A;
  assign diff_lower = char_code - CHAR_LOWER_A;
  assign diff_digit = char_code - CHAR_DIGIT_0;

  // Later alphabet index wins: 63 over 62 over the fixed groups
  always_comb begin
    sym_known = 1'b1;
    sym_val   = '0;
    priority if (char_code == sym63) begin
      sym_val = VAL_SYM63;
    end else if (char_code == sym62) begin
      sym_val = VAL_SYM62;
    end else if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_Z) begin
      sym_val = diff_upper[5:0];
    end else if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) begin
      sym_val = diff_lower[5:0] + VAL_LOWER_BASE;
    end else if (char_code >= CHAR_DIGIT_0 && char_code <= CHAR_DIGIT_9) begin
      sym_val = diff_digit[5:0] + VAL_DIGIT_BASE;
    end else begin
      sym_known = 1'b0;
    end
  end

  // count + 6: bit 3 set means a full byte is ready, low bits are what stays
  assign acc         = {state_cur.bits, sym_val};
  assign cnt_sum     = {1'b0, state_cur.count} + 4'd6;
  assign cnt_left    = cnt_sum[2:0];
  assign acc_shifted = acc >> cnt_left;
  assign keep_mask   = (7'd1 << cnt_left) - 7'd1;

  always_comb begin
    upd  = state_cur;
    emit = 1'b0;
    if (state_cur.err == STATUS_OK) begin
      if (char_code == CHAR_PAD) begin
        upd.pad_seen = 1'b1;
      end else if (!sym_known || state_cur.pad_seen) begin
        upd.err = STATUS_BAD_CHAR;
      end else begin
        emit      = cnt_sum[3];
        upd.bits  = acc[5:0] & keep_mask[5:0];
        upd.count = cnt_left;
      end
    end
    if (last_char && upd.err == STATUS_OK) begin
      if (upd.count >= 3'd6 || upd.bits != '0) begin
        upd.err = STATUS_TRAILING;
      end
    end
  end

  assign result.byte_valid   = emit;
  assign result.decoded_byte = emit ? acc_shifted[7:0] : 8'd0;
  assign result.message_end  = last_char;
  assign result.status       = upd.err;

  assign state_nxt = last_char ? msg_state_t'('0) : upd;

endmodule

`default_nettype wire

### hw/rtl/strict_base64_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Strict Base64 decoder. One character word enters per cycle on in_ch and
// gives exactly one result word on out_ch the cycle after: an optional
// decoded byte, a message_end flag that copies last_char, and the message's
// sticky status (0 ok, 1 bad character or symbol after '=', 2 bad trailing
// bits at the last character). Throughput is one word per clock; the only
// stage is the result register, and in_ch.ready drops only while a result
// sits there unaccepted. The symbols that decode to 62 and 63 are set over
// the APB port: register 0 at address 0 (reset '+'), register 1 at address 4
// (reset '/'); write them only while no message is in flight. '=' is always
// padding, even when a register holds its code. Once an error is flagged the
// rest of the message produces no bytes; all decoder state clears after the
// result for the last character.
module strict_base64_decoder_core
  import b64d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  b64d_in_if.sink          in_ch,
  b64d_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  // Alphabet registers
  logic [7:0] sym62_r;
  logic [7:0] sym63_r;
  logic       cfg_wr;

  // Decoder state and result stage
  msg_state_t state_r;
  msg_state_t state_nxt;
  result_t    result_nxt;
  result_t    out_data_r;
  logic       out_valid_r;
  logic       in_acc;

  // --- APB: zero wait states, paddr[2] picks the register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym62_r <= SYM62_RESET;
      sym63_r <= SYM63_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_SYM62: sym62_r <= cfg_pwdata[7:0];
        REG_SYM63: sym63_r <= cfg_pwdata[7:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SYM62: cfg_prdata = {24'd0, sym62_r};
      REG_SYM63: cfg_prdata = {24'd0, sym63_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // --- decode step
  b64d_step u_step (
    .char_code (in_ch.char_code),
    .last_char (in_ch.last_char),
    .sym62     (sym62_r),
    .sym63     (sym63_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // take a new word whenever the result slot is empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.byte_valid   = out_data_r.byte_valid;
  assign out_ch.decoded_byte = out_data_r.decoded_byte;
  assign out_ch.message_end  = out_data_r.message_end;
  assign out_ch.status       = out_data_r.status;

  // --- checks

  // leftover count only ever holds 0, 2, 4 or 6
  a_count_even: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.count[0] == 1'b0)
    else $error("leftover count is odd");

  // state clears after the last character of a message
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.last_char |=> state_r == msg_state_t'('0))
    else $error("state not cleared at message end");

  // an error holds until the message ends
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_ch.last_char && state_r.err != STATUS_OK
    |=> state_r.err == $past(state_r.err))
    else $error("sticky error changed inside a message");

  // a bad character never comes with a byte
  a_no_byte_on_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.byte_valid |-> out_data_r.status != STATUS_BAD_CHAR)
    else $error("byte delivered with bad-character status");

endmodule

`default_nettype wire

### bench/strict_base64_decoder_core_tb.sv
`timescale 1ns / 1ps

import b64d_pkg::*;

// Scoreboard: tracks the per-message decode state and queues the result
// word that each accepted character word must produce.
class decode_scoreboard;

  logic [7:0] sym62;
  logic [7:0] sym63;
  logic [5:0] left_bits;
  logic [2:0] left_cnt;
  logic       pad_seen;
  logic [1:0] err;
  result_t    expected_q[$];
  int         mismatches;

  function new();
    sym62      = SYM62_RESET;
    sym63      = SYM63_RESET;
    mismatches = 0;
    clear_message();
  endfunction

  function void clear_message();
    left_bits = '0;
    left_cnt  = '0;
    pad_seen  = 1'b0;
    err       = STATUS_OK;
  endfunction

  function void set_symbol(logic idx, logic [7:0] value);
    if (idx == REG_SYM62) sym62 = value;
    else sym63 = value;
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function string fmt(result_t r);
    return $sformatf("byte_valid=%0d byte=%02h end=%0d status=%0d",
                     r.byte_valid, r.decoded_byte, r.message_end, r.status);
  endfunction

  // Accepted character word: advance the decode state, queue its result.
  function void note_char(logic [7:0] c, logic last);
    result_t     r;
    int          v;
    int          cnt;
    logic [11:0] acc;
    r = '0;
    if (err == STATUS_OK) begin
      if (c == CHAR_PAD) begin
        pad_seen = 1'b1;
      end else begin
        // later alphabet index wins: 63 over 62, both over letters/digits
        if (c == sym63) v = VAL_SYM63;
        else if (c == sym62) v = VAL_SYM62;
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) v = int'(c - CHAR_UPPER_A);
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
          v = int'(c - CHAR_LOWER_A) + VAL_LOWER_BASE;
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
          v = int'(c - CHAR_DIGIT_0) + VAL_DIGIT_BASE;
        else v = -1;
        if (v < 0 || pad_seen) begin
          err = STATUS_BAD_CHAR;
        end else begin
          acc = {left_bits, 6'(v)};
          cnt = int'(left_cnt) + 6;
          if (cnt >= 8) begin
            cnt -= 8;
            r.byte_valid   = 1'b1;
            r.decoded_byte = 8'(acc >> cnt);
          end
          left_bits = 6'(acc & ((12'd1 << cnt) - 12'd1));
          left_cnt  = 3'(cnt);
        end
      end
    end
    if (last && err == STATUS_OK && (left_cnt >= 3'd6 || left_bits != '0))
      err = STATUS_TRAILING;
    r.message_end = last;
    r.status      = err;
    expected_q = {expected_q, r};
    if (last) clear_message();
  endfunction

  function void check_result(result_t got);
    result_t exp;
    if (expected_q.size() == 0) begin
      report({"unexpected result word: ", fmt(got)});
      return;
    end
    exp = expected_q.pop_front();
    if (got.byte_valid !== exp.byte_valid || got.decoded_byte !== exp.decoded_byte ||
        got.message_end !== exp.message_end || got.status !== exp.status)
      report({"result mismatch: expected ", fmt(exp), " got ", fmt(got)});
  endfunction
endclass

module strict_base64_decoder_core_tb;
  import b64d_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no word accepted
  localparam int SETTLE_CYCLES   = 4;     // one result stage, plus margin
  localparam int CHARS_PER_PHASE = 175;
  localparam int HOLD_OFF_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  b64d_in_if  in_ch ();
  b64d_out_if out_ch ();

  strict_base64_decoder_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  decode_scoreboard chk = new();

  // Traffic shaping, set by the main sequence at rising edges; the receiver
  // reads its knobs and counts the hold-off down at falling edges.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;
  int chars_sent     = 0;
  int quiet_cycles   = 0;

  // Encoder-side copy of the alphabet registers, for building messages.
  logic [7:0] cur_sym62 = SYM62_RESET;
  logic [7:0] cur_sym63 = SYM63_RESET;

  result_t seen_result;

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: note accepted characters, check accepted results, and run the
  // watchdog on cycles where neither channel moves a word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire) chk.note_char(in_ch.char_code, in_ch.last_char);
      if (out_fire) begin
        seen_result.byte_valid   = out_ch.byte_valid;
        seen_result.decoded_byte = out_ch.decoded_byte;
        seen_result.message_end  = out_ch.message_end;
        seen_result.status       = out_ch.status;
        chk.check_result(seen_result);
      end
      if (in_fire || out_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls at the phase's rate; a requested hold-off keeps
  // ready low for a long run so the result stage fills and in_ch backs up.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Value -> character under the current alphabet settings.
  function automatic logic [7:0] symbol_char(logic [5:0] v);
    if (v == VAL_SYM63) return cur_sym63;
    if (v == VAL_SYM62) return cur_sym62;
    if (v >= VAL_DIGIT_BASE) return CHAR_DIGIT_0 + 8'(v - VAL_DIGIT_BASE);
    if (v >= VAL_LOWER_BASE) return CHAR_LOWER_A + 8'(v - VAL_LOWER_BASE);
    return CHAR_UPPER_A + 8'(v);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // without having touched in_ch in that step, so valid can stay high.
  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Mostly well-formed encodings of random bytes, some with broken tails or
  // stray symbols, and a few of pure noise.
  task automatic send_random_message();
    logic [7:0]  msg[$];
    logic [15:0] acc;
    int          nbits;
    int          kind;
    int          pos;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 10)) msg = {msg, 8'($urandom_range(255))};
    end else begin
      acc   = '0;
      nbits = 0;
      repeat ($urandom_range(1, 9)) begin
        acc = {acc[7:0], 8'($urandom_range(255))};
        nbits += 8;
        while (nbits >= 6) begin
          nbits -= 6;
          msg = {msg, symbol_char(6'(acc >> nbits))};
        end
      end
      // tail symbol carries the leftover bits, zero filled
      if (nbits > 0) msg = {msg, symbol_char(6'(acc << (6 - nbits)))};
      if ($urandom_range(3) != 0)
        while (msg.size() % 4 != 0) msg = {msg, CHAR_PAD};
      if (kind >= 80) begin
        pos = $urandom_range(msg.size() - 1);
        case ($urandom_range(3))
          0: msg[pos] = 8'($urandom_range(255));
          1: msg.insert(pos, CHAR_PAD);       // padding followed by symbols
          2: if (msg.size() > 1) msg.delete(pos);
          default: msg[msg.size() - 1] = symbol_char(6'($urandom_range(63)));
        endcase
      end
    end
    foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
  endtask

  // APB write, then read back. Starts on the next falling edge and ends on a
  // falling edge with psel dropped.
  task automatic cfg_write(logic idx, logic [7:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'h0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    chk.set_symbol(idx, value);
    if (idx == REG_SYM62) cur_sym62 = value;
    else cur_sym63 = value;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== value)
      chk.report($sformatf("register %0d readback: expected %02h got %02h",
                           idx, value, cfg_prdata[7:0]));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Wait until every result is in and the single result stage has emptied.
  task automatic wait_drained();
    do @(posedge clk); while (chk.expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random phase: new alphabet, new traffic shape. Phases only start
  // between messages, so the registers change with no message in flight.
  task automatic run_phase(logic [7:0] s62, logic [7:0] s63, int idle_pct,
                           int stall_pct, int hold);
    wait_drained();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_off_left  = hold;
    cfg_write(REG_SYM62, s62);
    cfg_write(REG_SYM63, s63);
    chars_sent = 0;
    while (chars_sent < CHARS_PER_PHASE) send_random_message();
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset alphabet, no idling.
    send_text("TWFu");   // three full bytes, clean end
    send_text("TWE=");   // two bytes, padding, zero trailing bits
    send_text("+/");     // 62 and 63; byte comes out but trailing bits are set
    send_text("A");      // six leftover bits at the end
    send_text("A=A");    // symbol after padding
    send_text("Za09");   // letter and digit range edges
    send_text("=");      // padding only
    send_char(8'h00, 1'b0);  // bad character, rest of message ignored
    send_char(8'hFF, 1'b1);
    in_ch.valid <= 1'b0;

    // Alphabet variants and register extremes, across the traffic shapes.
    run_phase("-", "_", 0, 0, HOLD_OFF_CYCLES);  // URL; receiver holds off
    run_phase("+", "~", 65, 0, 0);               // tilde variant
    run_phase(8'h00, 8'hFF, 0, 65, 0);
    run_phase(8'hFF, 8'h00, 17, 17, 0);
    run_phase("A", "A", 0, 0, 0);                // both clash with a letter
    run_phase("9", "=", 65, 0, 0);               // padding beats register 1
    run_phase("+", "/", 0, 65, 0);
    run_phase("-", "-", 17, 17, 0);              // register 1 wins the tie

    wait_drained();
    if (chk.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
